[hdl/bqf_pkg.sv]
// Shared constants, types and saturation functions of the biquad filter.
package bqf_pkg;

   localparam int CHANNELS    = 2;
   localparam int SAMPLE_BITS = 24;

   localparam int COEF_W      = 32;
   localparam int COEF_FRAC   = 28;
   localparam int STATE_FRAC  = 16;
   localparam int STATE_W     = 48;
   localparam int PROD_SHIFT  = COEF_FRAC - STATE_FRAC;
   localparam int FULL_W      = COEF_W + SAMPLE_BITS;
   localparam int PROD_W      = FULL_W - PROD_SHIFT;
   localparam int ACC_W       = ((PROD_W > STATE_W) ? PROD_W : STATE_W) + 2;
   localparam int CH_ID_W     = 2;
   localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CSR_AW      = 3;

   localparam logic [CSR_AW-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_AW-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_AW-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_AW-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_AW-1:0] REG_A2 = 3'd4;

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

   localparam logic [CH_ID_W:0] CH_COUNT = (CH_ID_W + 1)'(CHANNELS);

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (STATE_FRAC - 1);

   localparam logic signed [ACC_W-1:0] Y_MAX =
      {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] Y_MIN =
      {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
   localparam logic signed [ACC_W-1:0] S_MAX =
      {{(ACC_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] S_MIN =
      {{(ACC_W - STATE_W + 1){1'b1}}, {(STATE_W - 1){1'b0}}};

   typedef struct packed {
      logic               rd;
      logic               wr;
      logic [CH_AW-1:0]   addr;
      logic [STATE_W-1:0] d1;
      logic [STATE_W-1:0] d2;
   } mem_req_type;

   typedef struct packed {
      logic [STATE_W-1:0] d1;
      logic [STATE_W-1:0] d2;
   } mem_data_type;

   function automatic logic [SAMPLE_BITS-1:0] sat_sample(logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > Y_MAX) begin
         r = Y_MAX;
      end else if (v < Y_MIN) begin
         r = Y_MIN;
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic [STATE_W-1:0] sat_state(logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > S_MAX) begin
         r = S_MAX;
      end else if (v < S_MIN) begin
         r = S_MIN;
      end
      return r[STATE_W-1:0];
   endfunction

endpackage

[hdl/bqf_state_mem.sv]
// Per-channel delay state memory with registered read and valid bits.
module bqf_state_mem
   import bqf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mem_req_type  req,
   output mem_data_type rd_data
);

   mem_data_type            mem [CHANNELS];
   mem_data_type            rd_ff;
   logic [CHANNELS-1:0]     valid_ff;
   logic [CHANNELS-1:0]     valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (req.wr) begin
         valid_in[req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.addr] <= '{d1: req.d1, d2: req.d2};
      end
      if (req.rd) begin
         if (valid_ff[req.addr]) begin
            rd_ff <= mem[req.addr];
         end else begin
            rd_ff <= '0;
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

[hdl/bqf_mult.sv]
// Shared coefficient-by-sample multiplier with registered, floor-shifted product.
module bqf_mult
   import bqf_pkg::*;
(
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [COEF_W-1:0]      coef,
   input  logic signed [SAMPLE_BITS-1:0] operand,
   output logic signed [PROD_W-1:0]      prod
);

   logic signed [FULL_W-1:0] full;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign full    = coef * operand;
   assign prod_in = full[FULL_W-1:PROD_SHIFT];

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[hdl/biquad_iir_filter.sv]
// Multi-channel transposed direct form II biquad filter, top level.
//
//   channel   ports                      word
//   --------  -------------------------  ------------------------------------
//   request   req_tvalid/tready/tdata    tdata: sample_in; tuser: channel_id
//   response  rsp_tvalid/tready/tdata    tdata: sample_out; tuser: channel_out
//   config    csr_we/addr/wdata          coef_b0, b1, b2, a1, a2 (Q4.28)
//
// A sample on a built channel makes five passes through the one 32x24
// multiplier, the first alongside the state read, then the state write-back
// and a return to idle; a new sample is accepted only in idle. Samples on
// other channels pass through unchanged via the pass state.
// Synchronous reset loads the coefficient defaults and clears the state
// valid bits at once; no clearing pass. A stalled response holds the
// write-back step until the output register frees.
module biquad_iir_filter
   import bqf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_BITS-1:0] req_tdata,  // [23:0] sample_in
   input  logic [CH_ID_W-1:0]     req_tuser,  // [1:0] channel_id

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SAMPLE_BITS-1:0] rsp_tdata,  // [23:0] sample_out
   output logic [CH_ID_W-1:0]     rsp_tuser,  // [1:0] channel_out

   input  logic                   csr_we,
   input  logic [CSR_AW-1:0]      csr_addr,
   input  logic [COEF_W-1:0]      csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_P0   = 3'd1;
   localparam logic [2:0] ST_Y    = 3'd2;
   localparam logic [2:0] ST_A1   = 3'd3;
   localparam logic [2:0] ST_B2   = 3'd4;
   localparam logic [2:0] ST_A2   = 3'd5;
   localparam logic [2:0] ST_WB   = 3'd6;
   localparam logic [2:0] ST_PASS = 3'd7;

   logic signed [COEF_W-1:0]      b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   logic [2:0]                    state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [CH_ID_W-1:0]            ch_ff, ch_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic signed [STATE_W-1:0]     d2_ff, d2_in;
   logic signed [STATE_W-1:0]     d1n_ff, d1n_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]        rsp_data_ff, rsp_data_in;
   logic [CH_ID_W-1:0]            rsp_user_ff, rsp_user_in;

   logic                          mult_en;
   logic signed [COEF_W-1:0]      mult_coef;
   logic signed [SAMPLE_BITS-1:0] mult_opd;
   logic signed [PROD_W-1:0]      prod;
   logic signed [ACC_W-1:0]       prod_ext;

   mem_req_type                   mem_req;
   mem_data_type                  mem_rd;

   logic signed [ACC_W-1:0]       sum_y;
   logic signed [ACC_W-1:0]       y_wide;
   logic signed [ACC_W-1:0]       d2_wide;
   logic                          out_free;
   logic                          accept;

   bqf_mult u_mult (
      .clock   (clock),
      .enable  (mult_en),
      .coef    (mult_coef),
      .operand (mult_opd),
      .prod    (prod)
   );

   bqf_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (mem_req),
      .rd_data (mem_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= COEF_ONE;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_B0:  b0_ff <= csr_wdata;
            REG_B1:  b1_ff <= csr_wdata;
            REG_B2:  b2_ff <= csr_wdata;
            REG_A1:  a1_ff <= csr_wdata;
            REG_A2:  a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign prod_ext   = ACC_W'(prod);

   assign sum_y   = prod_ext + ACC_W'($signed(mem_rd.d1)) + ROUND_HALF;
   assign y_wide  = sum_y >>> STATE_FRAC;
   assign d2_wide = acc_ff - prod_ext;

   always_comb begin
      mult_en   = 1'b1;
      mult_coef = b0_ff;
      mult_opd  = x_ff;
      unique case (state_ff)
         ST_P0: begin
            mult_coef = b0_ff;
            mult_opd  = x_ff;
         end
         ST_Y: begin
            mult_coef = b1_ff;
            mult_opd  = x_ff;
         end
         ST_A1: begin
            mult_coef = a1_ff;
            mult_opd  = y_ff;
         end
         ST_B2: begin
            mult_coef = b2_ff;
            mult_opd  = x_ff;
         end
         ST_A2: begin
            mult_coef = a2_ff;
            mult_opd  = y_ff;
         end
         default: begin
            mult_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      ch_in        = ch_ff;
      y_in         = y_ff;
      d2_in        = d2_ff;
      d1n_in       = d1n_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      mem_req      = '0;
      mem_req.addr = ch_ff[CH_AW-1:0];
      mem_req.d1   = d1n_ff;
      mem_req.d2   = sat_state(d2_wide);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in  = req_tdata;
               ch_in = req_tuser;
               if ({1'b0, req_tuser} < CH_COUNT) begin
                  state_in = ST_P0;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_P0: begin
            mem_req.rd = 1'b1;
            state_in   = ST_Y;
         end
         ST_Y: begin
            y_in     = sat_sample(y_wide);
            d2_in    = mem_rd.d2;
            state_in = ST_A1;
         end
         ST_A1: begin
            acc_in   = ACC_W'(d2_ff) + prod_ext;
            state_in = ST_B2;
         end
         ST_B2: begin
            acc_in   = acc_ff - prod_ext;
            state_in = ST_A2;
         end
         ST_A2: begin
            d1n_in   = sat_state(acc_ff);
            acc_in   = prod_ext;
            state_in = ST_WB;
         end
         ST_WB: begin
            if (out_free) begin
               mem_req.wr   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_ff;
               rsp_user_in  = ch_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_PASS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = x_ff;
               rsp_user_in  = ch_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      ch_ff       <= ch_in;
      y_ff        <= y_in;
      d2_ff       <= d2_in;
      d1n_ff      <= d1n_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
